// ===== rtl/sri_pkg.sv =====
// ----------------------------------------------------------------------------
// sri_pkg - shared types and helpers for the segment/rectangle test
// Coordinate, difference, product and sum widths, plus the vector helpers
// used by the edge test pipeline.
// ----------------------------------------------------------------------------
package sri_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [SUM_BITS-1:0]   t_sum;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    typedef struct packed {
        t_diff x;
        t_diff y;
    } t_vec;

    // two partial products of a cross or dot product
    typedef struct packed {
        t_prod l;
        t_prod r;
    } t_pair;

    function automatic t_vec f_vsub(input t_pt a, input t_pt b);
        t_vec v;
        v.x = t_diff'(a.x) - t_diff'(b.x);
        v.y = t_diff'(a.y) - t_diff'(b.y);
        return v;
    endfunction

    function automatic t_prod f_mul(input t_diff a, input t_diff b);
        t_prod p;
        p = t_prod'(a) * t_prod'(b);
        return p;
    endfunction

    function automatic t_pair f_cross_pp(input t_vec a, input t_vec b);
        t_pair p;
        p.l = f_mul(a.x, b.y);
        p.r = f_mul(a.y, b.x);
        return p;
    endfunction

    function automatic t_pair f_dot_pp(input t_vec a, input t_vec b);
        t_pair p;
        p.l = f_mul(a.x, b.x);
        p.r = f_mul(a.y, b.y);
        return p;
    endfunction

endpackage

// ===== rtl/segment_rectangle_intersect.sv =====
// ----------------------------------------------------------------------------
// segment_rectangle_intersect - segment versus axis-aligned rectangle test
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  query   | in        | i_valid / o_stall   | i_seg_*, i_rect_* (16b s)
//  answer  | out       | o_valid / i_stall   | o_hit
//
// One word per cycle while the answer side does not stall; a word passes the
// edge-test difference, product and meet stages, then the output register. The
// edge-test pipeline has a multiplier stage between difference and sum.
// Synchronous active-low reset clears the valid bits only.
// A stall on the answer side freezes the whole pipeline only when the output
// register holds a word; bubbles still fill while the output is empty.
// ----------------------------------------------------------------------------
module segment_rectangle_intersect
    import sri_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_coord i_seg_ax,
    input  t_coord i_seg_ay,
    input  t_coord i_seg_bx,
    input  t_coord i_seg_by,
    input  t_coord i_rect_x_one,
    input  t_coord i_rect_y_one,
    input  t_coord i_rect_x_two,
    input  t_coord i_rect_y_two,
    output logic   o_valid,
    input  logic   i_stall,
    output logic   o_hit
);

    logic       r_en;
    logic [2:0] r_vld;
    logic       r_out_vld;
    logic       r_hit;
    logic [2:0] r_ins;

    t_pt pa, pb, c11, c12, c21, c22;
    logic [3:0] meet;
    logic n_ins;

    assign r_en    = ~r_out_vld | ~i_stall;
    assign o_stall = ~r_en;

    always_comb begin
        pa  = '{x: i_seg_ax,     y: i_seg_ay};
        pb  = '{x: i_seg_bx,     y: i_seg_by};
        c11 = '{x: i_rect_x_one, y: i_rect_y_one};
        c12 = '{x: i_rect_x_one, y: i_rect_y_two};
        c21 = '{x: i_rect_x_two, y: i_rect_y_one};
        c22 = '{x: i_rect_x_two, y: i_rect_y_two};
    end

    sri_edge u_edge_0 (.i_clk(i_clk), .i_en(r_en), .i_pa(pa), .i_pb(pb),
                       .i_qa(c11), .i_qb(c12), .o_meet(meet[0]));
    sri_edge u_edge_1 (.i_clk(i_clk), .i_en(r_en), .i_pa(pa), .i_pb(pb),
                       .i_qa(c11), .i_qb(c21), .o_meet(meet[1]));
    sri_edge u_edge_2 (.i_clk(i_clk), .i_en(r_en), .i_pa(pa), .i_pb(pb),
                       .i_qa(c22), .i_qb(c12), .o_meet(meet[2]));
    sri_edge u_edge_3 (.i_clk(i_clk), .i_en(r_en), .i_pa(pa), .i_pb(pb),
                       .i_qa(c22), .i_qb(c21), .o_meet(meet[3]));

    // both ends inside, border included; corner order does not matter
    always_comb begin
        n_ins = (((i_seg_ax >= i_rect_x_one) && (i_seg_ax <= i_rect_x_two)) ||
                 ((i_seg_ax >= i_rect_x_two) && (i_seg_ax <= i_rect_x_one))) &&
                (((i_seg_ay >= i_rect_y_one) && (i_seg_ay <= i_rect_y_two)) ||
                 ((i_seg_ay >= i_rect_y_two) && (i_seg_ay <= i_rect_y_one))) &&
                (((i_seg_bx >= i_rect_x_one) && (i_seg_bx <= i_rect_x_two)) ||
                 ((i_seg_bx >= i_rect_x_two) && (i_seg_bx <= i_rect_x_one))) &&
                (((i_seg_by >= i_rect_y_one) && (i_seg_by <= i_rect_y_two)) ||
                 ((i_seg_by >= i_rect_y_two) && (i_seg_by <= i_rect_y_one)));
    end

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            r_ins <= {r_ins[1:0], n_ins};
            r_hit <= (|meet) | r_ins[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (r_en) begin
            r_vld     <= {r_vld[1:0], i_valid};
            r_out_vld <= r_vld[2];
        end
    end

    assign o_valid = r_out_vld;
    assign o_hit   = r_hit;

    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output register is free");

    a_frozen_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> ($stable(r_vld) && $stable(r_ins)))
        else $error("pipeline moved during a stall");

    a_word_reaches_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_en && r_vld[2]) |=> o_valid)
        else $error("word lost between last stage and output");

endmodule

// ===== rtl/sri_edge.sv =====
// ----------------------------------------------------------------------------
// sri_edge - three-stage segment/segment meet test
// Stage 1 takes differences, stage 2 the partial products, stage 3 the
// sums, their signs and the proper-crossing / collinear-touch decision.
// ----------------------------------------------------------------------------
module sri_edge
    import sri_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_pt  i_pa,
    input  t_pt  i_pb,
    input  t_pt  i_qa,
    input  t_pt  i_qb,
    output logic o_meet
);

    // stage 1: differences
    t_vec r_dp, r_dq;
    t_vec r_qa_pa, r_qb_pa, r_pa_qa, r_pb_qa;
    t_vec r_qa_pb, r_qb_pb, r_pa_qb, r_pb_qb;

    // stage 2: partial products
    t_pair r_c1, r_c2, r_c3, r_c4;
    t_pair r_w1, r_w2, r_w3, r_w4;

    // stage 3
    logic r_meet;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dp    <= f_vsub(i_pb, i_pa);
            r_dq    <= f_vsub(i_qb, i_qa);
            r_qa_pa <= f_vsub(i_qa, i_pa);
            r_qb_pa <= f_vsub(i_qb, i_pa);
            r_pa_qa <= f_vsub(i_pa, i_qa);
            r_pb_qa <= f_vsub(i_pb, i_qa);
            r_qa_pb <= f_vsub(i_qa, i_pb);
            r_qb_pb <= f_vsub(i_qb, i_pb);
            r_pa_qb <= f_vsub(i_pa, i_qb);
            r_pb_qb <= f_vsub(i_pb, i_qb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= f_cross_pp(r_dp, r_qa_pa);
            r_c2 <= f_cross_pp(r_dp, r_qb_pa);
            r_c3 <= f_cross_pp(r_dq, r_pa_qa);
            r_c4 <= f_cross_pp(r_dq, r_pb_qa);
            r_w1 <= f_dot_pp(r_qa_pa, r_qa_pb);
            r_w2 <= f_dot_pp(r_qb_pa, r_qb_pb);
            r_w3 <= f_dot_pp(r_pa_qa, r_pa_qb);
            r_w4 <= f_dot_pp(r_pb_qa, r_pb_qb);
        end
    end

    t_sum s_c1, s_c2, s_c3, s_c4;
    t_sum s_w1, s_w2, s_w3, s_w4;
    logic [3:0] c_neg, c_zero, c_pos, w_le;
    logic n_meet;

    always_comb begin
        s_c1 = t_sum'(r_c1.l) - t_sum'(r_c1.r);
        s_c2 = t_sum'(r_c2.l) - t_sum'(r_c2.r);
        s_c3 = t_sum'(r_c3.l) - t_sum'(r_c3.r);
        s_c4 = t_sum'(r_c4.l) - t_sum'(r_c4.r);
        s_w1 = t_sum'(r_w1.l) + t_sum'(r_w1.r);
        s_w2 = t_sum'(r_w2.l) + t_sum'(r_w2.r);
        s_w3 = t_sum'(r_w3.l) + t_sum'(r_w3.r);
        s_w4 = t_sum'(r_w4.l) + t_sum'(r_w4.r);

        c_neg  = {s_c4[SUM_BITS-1], s_c3[SUM_BITS-1], s_c2[SUM_BITS-1], s_c1[SUM_BITS-1]};
        c_zero = {s_c4 == '0, s_c3 == '0, s_c2 == '0, s_c1 == '0};
        c_pos  = ~c_neg & ~c_zero;
        // dot product not positive: point lies between the two ends
        w_le   = {s_w4[SUM_BITS-1] | (s_w4 == '0), s_w3[SUM_BITS-1] | (s_w3 == '0),
                  s_w2[SUM_BITS-1] | (s_w2 == '0), s_w1[SUM_BITS-1] | (s_w1 == '0)};

        n_meet = (((c_pos[0] & c_neg[1]) | (c_neg[0] & c_pos[1])) &
                  ((c_pos[2] & c_neg[3]) | (c_neg[2] & c_pos[3])))
                 | (|(c_zero & w_le));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meet <= n_meet;
        end
    end

    assign o_meet = r_meet;

endmodule
